[design/fhd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fhd_pkg;

  localparam logic [7:0]  MAGIC_A     = 8'h42;
  localparam logic [7:0]  MAGIC_B     = 8'h4E;
  localparam logic [7:0]  HDR_VERSION = 8'h01;
  localparam logic [3:0]  HDR_LEN     = 4'd9;
  localparam logic [3:0]  IDX_MAGIC_A = 4'd0;
  localparam logic [3:0]  IDX_MAGIC_B = 4'd1;
  localparam logic [3:0]  IDX_VERSION = 4'd2;
  localparam logic [3:0]  IDX_KIND_HI = 4'd3;
  localparam logic [3:0]  IDX_KIND_LO = 4'd4;
  localparam logic [32:0] COUNT_MAX   = {33{1'b1}};

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_MAGIC   = 3'd1,
    ST_VERSION = 3'd2,
    ST_SHORT   = 3'd3,
    ST_LENGTH  = 3'd4
  } status_t;

  typedef struct packed {
    logic        data_valid;
    logic [7:0]  payload_byte;
    logic [15:0] frame_kind;
    logic [31:0] declared_length;
    logic        frame_end;
    status_t     frame_status;
  } result_t;

endpackage

`default_nettype wire

[design/fhd_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module fhd_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic [7:0]      in_byte,
  input  wire logic            in_last,
  output logic                 produce,
  output fhd_pkg::result_t     res
);

  logic [3:0]       header_index, header_index_next;
  logic [15:0]      kind_shift, kind_shift_next;
  logic [31:0]      length_shift, length_shift_next;
  logic [32:0]      payload_count, payload_count_next;
  fhd_pkg::status_t error_code, error_code_next;

  always_comb begin
    fhd_pkg::status_t hdr_err;
    fhd_pkg::status_t status;
    logic             data;

    hdr_err            = fhd_pkg::ST_OK;
    data               = 1'b0;
    status             = fhd_pkg::ST_OK;
    header_index_next  = header_index;
    kind_shift_next    = kind_shift;
    length_shift_next  = length_shift;
    payload_count_next = payload_count;

    if (header_index != fhd_pkg::HDR_LEN) begin
      case (header_index)
        fhd_pkg::IDX_MAGIC_A: begin
          if (in_byte != fhd_pkg::MAGIC_A) hdr_err = fhd_pkg::ST_MAGIC;
        end
        fhd_pkg::IDX_MAGIC_B: begin
          if (in_byte != fhd_pkg::MAGIC_B) hdr_err = fhd_pkg::ST_MAGIC;
        end
        fhd_pkg::IDX_VERSION: begin
          if (in_byte != fhd_pkg::HDR_VERSION) hdr_err = fhd_pkg::ST_VERSION;
        end
        fhd_pkg::IDX_KIND_HI, fhd_pkg::IDX_KIND_LO: begin
          kind_shift_next = {kind_shift[7:0], in_byte};
        end
        default: begin
          length_shift_next = {length_shift[23:0], in_byte};
        end
      endcase
      header_index_next = header_index + 4'd1;
    end else begin
      data = (error_code == fhd_pkg::ST_OK) && (payload_count < {1'b0, length_shift});
      if (payload_count != fhd_pkg::COUNT_MAX) payload_count_next = payload_count + 33'd1;
    end

    error_code_next = (error_code == fhd_pkg::ST_OK) ? hdr_err : error_code;

    if (in_last) begin
      if (error_code_next != fhd_pkg::ST_OK) begin
        status = error_code_next;
      end else if (header_index_next != fhd_pkg::HDR_LEN) begin
        status = fhd_pkg::ST_SHORT;
      end else if (payload_count_next != {1'b0, length_shift_next}) begin
        status = fhd_pkg::ST_LENGTH;
      end
    end

    produce             = in_last || data;
    res.data_valid      = data;
    res.payload_byte    = data ? in_byte : 8'd0;
    res.frame_kind      = kind_shift_next;
    res.declared_length = length_shift_next;
    res.frame_end       = in_last;
    res.frame_status    = status;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && in_last)) begin
      header_index  <= '0;
      kind_shift    <= '0;
      length_shift  <= '0;
      payload_count <= '0;
      error_code    <= fhd_pkg::ST_OK;
    end else if (step) begin
      header_index  <= header_index_next;
      kind_shift    <= kind_shift_next;
      length_shift  <= length_shift_next;
      payload_count <= payload_count_next;
      error_code    <= error_code_next;
    end
  end

endmodule

`default_nettype wire

[design/frame_header_deframer.sv]
// Frame header deframer.
// Slave channel: one frame byte per item on s_tdata, s_tlast on the last
// byte of a frame. Master channel: one item per payload byte passed out and
// one item (tlast set) for the last byte of every frame, carrying the final
// status; downstream drops the frame's payload when that status is not ok.
// Header bytes other than the last produce no item.
// Path: an accepted byte lands in the input register and is checked there;
// its item is loaded into the output register when the byte steps on, and
// m_tvalid rises with that load.
// Throughput: one byte per cycle unless stalled as below; each accepted byte
// updates the header index, shift registers and 33-bit payload counter.
// Stall: while a result waits in the output register, bytes that produce no
// item keep flowing; a byte that produces an item waits in the input
// register until the output register is taken, with s_tready low meanwhile.
// Reset (rst, synchronous) empties both registers and clears the frame
// state; the state also clears after the last byte of every frame.
`timescale 1ns / 1ps
`default_nettype none

module frame_header_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // in_byte
  input  wire logic        s_tlast,   // frame_last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // payload_byte, declared_length, frame_status, zero fill
  output logic [16:0]      m_tuser,   // data_valid, frame_kind
  output logic             m_tlast    // frame_end
);

  logic              in_valid;
  logic [7:0]        in_byte;
  logic              in_last;
  logic              out_valid;
  fhd_pkg::result_t  out_res;
  fhd_pkg::result_t  res;
  logic              produce;
  logic              step;

  assign step     = in_valid && (!produce || !out_valid || m_tready);
  assign s_tready = !in_valid || step;

  fhd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_byte (in_byte),
    .in_last (in_last),
    .produce (produce),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && produce) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && produce) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_res.frame_status, out_res.declared_length, out_res.payload_byte};
  assign m_tuser  = {out_res.frame_kind, out_res.data_valid};
  assign m_tlast  = out_res.frame_end;

`ifndef ASSERT_OFF
  a_item_has_content: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.data_valid || out_res.frame_end))
    else $error("result item with neither payload nor frame end");

  a_status_on_end_only: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.frame_end) |-> (out_res.frame_status == fhd_pkg::ST_OK))
    else $error("status reported before frame end");

  a_payload_zero_when_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.data_valid) |-> (out_res.payload_byte == 8'd0))
    else $error("payload byte set without data_valid");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |=> (out_valid && $stable(out_res)))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

[bench/frame_header_deframer_tb.sv]
`timescale 1ns / 1ps

module frame_header_deframer_tb;

  class deframe_scoreboard;
    logic [3:0]       hdr_idx;
    logic [15:0]      kind_sr;
    logic [31:0]      len_sr;
    logic [32:0]      pay_cnt;
    fhd_pkg::status_t fault;
    fhd_pkg::result_t awaited[$];
    int               errors;
    int               n_bytes;
    int               n_frames;
    int               n_payload;
    int               n_checked;

    function new();
      clear_frame();
      errors    = 0;
      n_bytes   = 0;
      n_frames  = 0;
      n_payload = 0;
      n_checked = 0;
    endfunction

    function void clear_frame();
      hdr_idx = '0;
      kind_sr = '0;
      len_sr  = '0;
      pay_cnt = '0;
      fault   = fhd_pkg::ST_OK;
    endfunction

    // first error in stream order wins
    function void note_fault(fhd_pkg::status_t code);
      if (fault == fhd_pkg::ST_OK) fault = code;
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    function void byte_accepted(logic [7:0] b, logic last);
      logic             data;
      fhd_pkg::status_t st;
      fhd_pkg::result_t r;
      data = 1'b0;
      st   = fhd_pkg::ST_OK;
      n_bytes++;
      if (hdr_idx < fhd_pkg::HDR_LEN) begin
        case (hdr_idx)
          fhd_pkg::IDX_MAGIC_A: if (b != fhd_pkg::MAGIC_A) note_fault(fhd_pkg::ST_MAGIC);
          fhd_pkg::IDX_MAGIC_B: if (b != fhd_pkg::MAGIC_B) note_fault(fhd_pkg::ST_MAGIC);
          fhd_pkg::IDX_VERSION:
            if (b != fhd_pkg::HDR_VERSION) note_fault(fhd_pkg::ST_VERSION);
          fhd_pkg::IDX_KIND_HI, fhd_pkg::IDX_KIND_LO: kind_sr = {kind_sr[7:0], b};
          default: len_sr = {len_sr[23:0], b};
        endcase
        hdr_idx = hdr_idx + 4'd1;
      end else begin
        if (fault == fhd_pkg::ST_OK && pay_cnt < {1'b0, len_sr}) data = 1'b1;
        if (pay_cnt != fhd_pkg::COUNT_MAX) pay_cnt = pay_cnt + 33'd1;
      end
      if (last || data) begin
        if (last) begin
          if (fault != fhd_pkg::ST_OK) st = fault;
          else if (hdr_idx < fhd_pkg::HDR_LEN) st = fhd_pkg::ST_SHORT;
          else if (pay_cnt != {1'b0, len_sr}) st = fhd_pkg::ST_LENGTH;
        end
        r.data_valid      = data;
        r.payload_byte    = data ? b : 8'h00;
        r.frame_kind      = kind_sr;
        r.declared_length = len_sr;
        r.frame_end       = last;
        r.frame_status    = st;
        awaited.insert(awaited.size(), r);
        if (data) n_payload++;
      end
      if (last) begin
        n_frames++;
        clear_frame();
      end
    endfunction

    task result_seen(fhd_pkg::result_t got);
      fhd_pkg::result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing pending: kind=%h len=%h end=%b",
                         got.frame_kind, got.declared_length, got.frame_end));
        return;
      end
      want = awaited.pop_front();
      n_checked++;
      if (got.data_valid !== want.data_valid)
        report($sformatf("data_valid got %b want %b", got.data_valid, want.data_valid));
      if (got.payload_byte !== want.payload_byte)
        report($sformatf("payload_byte got %h want %h", got.payload_byte, want.payload_byte));
      if (got.frame_kind !== want.frame_kind)
        report($sformatf("frame_kind got %h want %h", got.frame_kind, want.frame_kind));
      if (got.declared_length !== want.declared_length)
        report($sformatf("declared_length got %h want %h",
                         got.declared_length, want.declared_length));
      if (got.frame_end !== want.frame_end)
        report($sformatf("frame_end got %b want %b", got.frame_end, want.frame_end));
      if (got.frame_status !== want.frame_status)
        report($sformatf("frame_status got %0d want %0d",
                         got.frame_status, want.frame_status));
    endtask
  endclass

  localparam int RAND_BYTES = 1200;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [16:0] m_tuser;
  logic        m_tlast;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_left      = 0;

  logic [7:0] frame_q[$];
  deframe_scoreboard sb = new();

  frame_header_deframer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // receiver: long hold-off when requested, random stalls otherwise
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    fhd_pkg::result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.data_valid      = m_tuser[0];
      got.frame_kind      = m_tuser[16:1];
      got.payload_byte    = m_tdata[7:0];
      got.declared_length = m_tdata[39:8];
      got.frame_status    = fhd_pkg::status_t'(m_tdata[42:40]);
      got.frame_end       = m_tlast;
      sb.result_seen(got);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.byte_accepted(b, last);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++)
      send_byte(frame_q[i], i == frame_q.size() - 1);
    frame_q.delete();
  endtask

  task automatic add_byte(input logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endtask

  task automatic put_header(input logic [15:0] kind, input logic [31:0] len,
                            input logic [7:0] m0, input logic [7:0] m1,
                            input logic [7:0] ver);
    add_byte(m0);
    add_byte(m1);
    add_byte(ver);
    add_byte(kind[15:8]);
    add_byte(kind[7:0]);
    add_byte(len[31:24]);
    add_byte(len[23:16]);
    add_byte(len[15:8]);
    add_byte(len[7:0]);
  endtask

  task automatic put_good_header(input logic [15:0] kind, input logic [31:0] len);
    put_header(kind, len, fhd_pkg::MAGIC_A, fhd_pkg::MAGIC_B, fhd_pkg::HDR_VERSION);
  endtask

  task automatic put_payload(input int n);
    repeat (n) add_byte(8'($urandom));
  endtask

  task automatic random_frame();
    int          r;
    int          len;
    int          d;
    logic [31:0] big;
    r   = $urandom_range(99);
    len = $urandom_range(16);
    if (r < 68) begin
      put_good_header(16'($urandom), len);
      put_payload(len);
    end else if (r < 78) begin
      // payload one to three bytes off the declared length
      d = $urandom_range(1, 3);
      put_good_header(16'($urandom), len);
      if ($urandom_range(1) == 0 || len < d) put_payload(len + d);
      else put_payload(len - d);
    end else if (r < 83) begin
      big = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : 32'($urandom);
      put_good_header(16'($urandom), big);
      put_payload($urandom_range(8));
    end else if (r < 89) begin
      d = $urandom_range(2);
      put_good_header(16'($urandom), len);
      frame_q[d] = 8'($urandom);
      put_payload($urandom_range(8));
    end else if (r < 95) begin
      put_good_header(16'($urandom), 32'($urandom));
      d = $urandom_range(1, 8);
      while (frame_q.size() > d) void'(frame_q.pop_back());
    end else begin
      put_payload($urandom_range(1, 12));
    end
    send_frame();
  endtask

  // stop sending and wait for every pending result
  task automatic wait_drain();
    int n;
    n = 0;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.awaited.size() != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    if (sb.awaited.size() != 0)
      sb.report($sformatf("%0d results still pending after drain", sb.awaited.size()));
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int start;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // header only, zero length
    put_good_header(16'h0000, 32'h0000_0000);
    send_frame();
    // last byte carries payload
    put_good_header(16'hFFFF, 32'd3);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'hA5);
    send_frame();
    // one-byte frame: short header
    add_byte(fhd_pkg::MAGIC_A);
    send_frame();
    // bad magic and bad version: magic wins
    put_header(16'h1234, 32'd2, 8'h00, fhd_pkg::MAGIC_B, 8'h02);
    put_payload(2);
    send_frame();
    // bad second magic byte
    put_header(16'h5A5A, 32'd1, fhd_pkg::MAGIC_A, 8'hFF, fhd_pkg::HDR_VERSION);
    put_payload(1);
    send_frame();
    // bad version
    put_header(16'hA5A5, 32'd0, fhd_pkg::MAGIC_A, fhd_pkg::MAGIC_B, 8'hFF);
    send_frame();
    // payload short of declared length
    put_good_header(16'h0001, 32'd2);
    put_payload(1);
    send_frame();
    // payload beyond declared length
    put_good_header(16'h8000, 32'd1);
    put_payload(3);
    send_frame();
    // largest declared length
    put_good_header(16'h7FFF, 32'hFFFF_FFFF);
    put_payload(2);
    send_frame();
    wait_drain();

    // receiver holds off while a long frame streams in
    hold_left = 60;
    put_good_header(16'hC0DE, 32'd40);
    put_payload(40);
    send_frame();
    wait_drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 46; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 46; end
        default: begin src_idle_pct = 18; sink_stall_pct = 18; end
      endcase
      start = sb.n_bytes;
      while (sb.n_bytes - start < RAND_BYTES / 4) random_frame();
      wait_drain();
    end

    if (sb.awaited.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.awaited.size()));
    $display("Sent %0d bytes in %0d frames under four idle/stall mixes and a long hold-off.",
             sb.n_bytes, sb.n_frames);
    $display("Checked %0d output items, %0d of them payload bytes.",
             sb.n_checked, sb.n_payload);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Run timed out with %0d results pending.", sb.awaited.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
